>>> design/subset_mean_threshold_count_assert.svh
// Assertion macros shared by the subset mean threshold counter.
`ifndef SUBSET_MEAN_THRESHOLD_COUNT_ASSERT_SVH
`define SUBSET_MEAN_THRESHOLD_COUNT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define SMTC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define SMTC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> design/smtc_pkg.sv
// Constants and widths for the subset mean threshold counter.
package smtc_pkg;

   localparam int MAX_ITEMS  = 32;
   localparam int MAX_SUBSET = 8;

   localparam int VALUE_W = 16;
   localparam int KCFG_W  = 4;
   localparam int CNT_W   = 24;
   localparam int ADDR_W  = $clog2(MAX_ITEMS);
   localparam int LEN_W   = $clog2(MAX_ITEMS + 1);
   localparam int SUB_W   = $clog2(MAX_SUBSET);
   localparam int PTR_W   = $clog2(MAX_SUBSET + 1);
   localparam int SUM_W   = VALUE_W + $clog2(MAX_SUBSET) + 1;

   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   localparam int CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_SUBSET_SIZE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_THRESHOLD = 1'd1;

endpackage

>>> design/subset_mean_threshold_count.sv
// Subset mean threshold counter: loads a value list, then counts k-subsets meeting a mean.
//
//   channel   direction  ports                                  handshake
//   request   in         req_value, req_is_last                 req_valid / req_ready
//   response  out        rsp_subset_count                       rsp_valid / rsp_ready
//   csr       in         csr_index, csr_wdata                   csr_we (no wait)
//
// Values load at one request per cycle while the block is in its load state.
// The request with is_last set starts the count: a setup step, then for each k-subset
// k reads through the registered memory port, the last add, a drain step and the
// compare and index step, then a done step. req_ready is low from the count until done;
// the next list may load while a response waits, and a count waits only if the previous
// one is pending. Reset is synchronous.
module subset_mean_threshold_count
   import smtc_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [VALUE_W-1:0]   req_value,
   input  logic                        req_is_last,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic        [CNT_W-1:0]     rsp_subset_count,
   input  logic                        csr_we,
   input  logic        [CSR_IDX_W-1:0] csr_index,
   input  logic        [VALUE_W-1:0]   csr_wdata
);

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_SETUP,
      ST_SUM,
      ST_CHECK,
      ST_DONE
   } state_type;

   // Control and datapath registers.
   state_type                 state_ff, state_in;
   logic [LEN_W-1:0]          len_ff, len_in;
   logic [PTR_W-1:0]          k_ff, k_in;
   logic signed [SUM_W-1:0]   target_ff, target_in;
   logic [ADDR_W-1:0]         idx_ff [MAX_SUBSET];
   logic [ADDR_W-1:0]         idx_in [MAX_SUBSET];
   logic [PTR_W-1:0]          rd_ptr_ff, rd_ptr_in;
   logic                      pend_ff, pend_in;
   logic signed [SUM_W-1:0]   sum_ff, sum_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [CNT_W-1:0]          rsp_count_ff, rsp_count_in;
   logic [KCFG_W-1:0]         cfg_k_ff;
   logic signed [VALUE_W-1:0] cfg_thr_ff;

   // Value memory with a registered read port.
   logic signed [VALUE_W-1:0] mem [MAX_ITEMS];
   logic signed [VALUE_W-1:0] rd_data_ff;

   logic                      req_fire;
   logic                      mem_we;
   logic                      rd_en;
   logic [ADDR_W-1:0]         rd_addr;
   logic [PTR_W-1:0]          k_clamped;
   logic [MAX_SUBSET-1:0]     can_adv;
   logic [SUB_W-1:0]          adv_pos;
   logic                      any_adv;
   logic [LEN_W:0]            limit;

   assign req_ready        = (state_ff == ST_LOAD);
   assign req_fire         = req_valid & req_ready;
   assign mem_we           = req_fire & (len_ff < LEN_W'(MAX_ITEMS));
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_subset_count = rsp_count_ff;

   // The subset positions are read one at a time through a small mux.
   assign rd_en   = (state_ff == ST_SUM) && (rd_ptr_ff < k_ff);
   assign rd_addr = idx_ff[rd_ptr_ff[SUB_W-1:0]];

   // Subset sizes below two count as two, those above the maximum as the maximum.
   always_comb begin
      if (cfg_k_ff < KCFG_W'(2)) begin
         k_clamped = PTR_W'(2);
      end else if (PTR_W'(cfg_k_ff) > PTR_W'(MAX_SUBSET)) begin
         k_clamped = PTR_W'(MAX_SUBSET);
      end else begin
         k_clamped = PTR_W'(cfg_k_ff);
      end
   end

   // Find the rightmost position that can still move up: position p may go up
   // while it stays below n - k + p. The last hit of the scan is the highest one.
   always_comb begin
      can_adv = '0;
      adv_pos = '0;
      any_adv = 1'b0;
      limit   = '0;
      for (int p = 0; p < MAX_SUBSET; p++) begin
         limit = {1'b0, len_ff} - (LEN_W + 1)'(k_ff) + (LEN_W + 1)'(p);
         can_adv[p] = ((LEN_W + 1)'(p) < (LEN_W + 1)'(k_ff)) &&
                      ((LEN_W + 1)'(idx_ff[p]) < limit);
         if (can_adv[p]) begin
            adv_pos = SUB_W'(p);
            any_adv = 1'b1;
         end
      end
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      k_in         = k_ff;
      target_in    = target_ff;
      idx_in       = idx_ff;
      rd_ptr_in    = rd_ptr_ff;
      pend_in      = 1'b0;
      sum_in       = sum_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_count_in = rsp_count_ff;

      case (state_ff)
         ST_LOAD: begin
            if (mem_we) begin
               len_in = len_ff + LEN_W'(1);
            end
            if (req_fire && req_is_last) begin
               k_in     = k_clamped;
               state_in = ST_SETUP;
            end
         end
         ST_SETUP: begin
            // The mean test is sum >= k * threshold, so no division is needed.
            target_in = SUM_W'(cfg_thr_ff) * $signed({1'b0, k_ff});
            for (int i = 0; i < MAX_SUBSET; i++) begin
               idx_in[i] = ADDR_W'(i);
            end
            rd_ptr_in = '0;
            sum_in    = '0;
            cnt_in    = '0;
            if (len_ff < LEN_W'(k_ff)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_SUM;
            end
         end
         ST_SUM: begin
            // Reads are issued one per cycle; each read word is added in the cycle after its read.
            if (rd_en) begin
               rd_ptr_in = rd_ptr_ff + PTR_W'(1);
            end
            pend_in = rd_en;
            if (pend_ff) begin
               sum_in = sum_ff + SUM_W'(rd_data_ff);
            end
            if (!rd_en && !pend_ff) begin
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if ((sum_ff >= target_ff) && (cnt_ff != COUNT_MAX)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (any_adv) begin
               // Step to the next subset in lexicographic order.
               for (int i = 0; i < MAX_SUBSET; i++) begin
                  if (SUB_W'(i) == adv_pos) begin
                     idx_in[i] = idx_ff[i] + ADDR_W'(1);
                  end else if (SUB_W'(i) > adv_pos) begin
                     idx_in[i] = idx_ff[adv_pos] + ADDR_W'(1) +
                                 ADDR_W'(SUB_W'(i) - adv_pos);
                  end
               end
               rd_ptr_in = '0;
               sum_in    = '0;
               state_in  = ST_SUM;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = cnt_ff;
               len_in       = '0;
               state_in     = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         len_ff       <= '0;
         k_ff         <= PTR_W'(2);
         rd_ptr_ff    <= '0;
         pend_ff      <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cfg_k_ff     <= KCFG_W'(2);
         cfg_thr_ff   <= '0;
         for (int i = 0; i < MAX_SUBSET; i++) begin
            idx_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         k_ff         <= k_in;
         rd_ptr_ff    <= rd_ptr_in;
         pend_ff      <= pend_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         idx_ff       <= idx_in;
         if (csr_we) begin
            case (csr_index)
               CSR_SUBSET_SIZE:    cfg_k_ff   <= csr_wdata[KCFG_W-1:0];
               CSR_MEAN_THRESHOLD: cfg_thr_ff <= csr_wdata;
               default: begin
               end
            endcase
         end
      end
   end

   // Datapath registers without reset.
   always_ff @(posedge clock) begin
      target_ff    <= target_in;
      sum_ff       <= sum_in;
      rsp_count_ff <= rsp_count_in;
   end

   // Value memory: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[len_ff[ADDR_W-1:0]] <= req_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

`include "subset_mean_threshold_count_assert.svh"

   // Only entries written in the current list are ever read.
   `SMTC_ASSERT_NOW(a_read_written, clock, reset, rd_en,
                    (LEN_W'(rd_addr) < len_ff), "read beyond stored list")
   // A new response only comes out of the done state.
   `SMTC_ASSERT_NOW(a_rsp_from_done, clock, reset, $rose(rsp_valid_ff),
                    ($past(state_ff) == ST_DONE), "response raised outside done state")
   // The match count never falls while subsets are being checked.
   `SMTC_ASSERT_NEXT(a_cnt_monotonic, clock, reset, (state_ff == ST_CHECK),
                     (cnt_ff >= $past(cnt_ff)), "match count decreased")

endmodule

>>> dv/subset_mean_threshold_count_tb.sv
// Self-checking testbench for the subset mean threshold counter.
module subset_mean_threshold_count_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import smtc_pkg::*;

   // Stimulus sizing. Sixteen register settings share about 1900 requests, and
   // they follow a short directed opening.
   localparam int PHASES          = 16;
   localparam int ITEMS_PER_PHASE = 118;
   // This is the quiet stretch that the block is given after the last expected
   // count has arrived, before a register is written or the run ends.
   localparam int QUIET_CYCLES    = 32;
   // This is the long receiver hold-off that forces the block to back up into its input.
   localparam int HOLD_CYCLES     = 2000;
   localparam int HOLD_PHASE      = 8;
   // A count walks all C(n,k) subsets. List lengths keep the run time of one count
   // under these budgets. The larger budget is drawn only rarely.
   localparam int NORMAL_BUDGET   = 3000;
   localparam int BIG_BUDGET      = 30000;
   // The slowest legal count and the long hold-off can come one after the other,
   // so the watchdog leaves a wide margin above both.
   localparam int WATCHDOG_LIMIT  = 200000;
   localparam int MAX_REPORTS     = 10;

   // These are the subset sizes written per phase. They include the values
   // that the block must clamp to 2 or to MAX_SUBSET.
   localparam int SIZE_TABLE [PHASES] = '{2, 3, 4, 5, 6, 7, 8, 0, 1, 9, 15, 2, 3, 8, 6, 4};
   // Each phase takes one of four idle mixes in turn: none, sender idle, receiver
   // stalling, and both lightly.
   localparam int SEND_IDLE [4] = '{0, 78, 0, 16};
   localparam int RSP_STALL [4] = '{0, 0, 78, 16};

   // The scoreboard keeps its own copy of the list and the registers. It works
   // out the count each time a list closes and checks counts in order.
   class subset_count_board;
      logic signed [VALUE_W-1:0] values [MAX_ITEMS];
      int unsigned               list_len;
      bit                        list_overflowed;
      logic [KCFG_W-1:0]         size_reg;
      logic signed [VALUE_W-1:0] threshold_reg;
      logic [CNT_W-1:0]          pending_counts [$];
      logic [CNT_W-1:0]          largest_count;
      int unsigned               mismatches;
      int unsigned               requests;
      int unsigned               lists_closed;
      int unsigned               short_lists;
      int unsigned               long_lists;

      function new();
         list_len        = 0;
         list_overflowed = 1'b0;
         size_reg        = KCFG_W'(2);
         threshold_reg   = '0;
         largest_count   = '0;
      endfunction

      static function int clamp_size(input logic [KCFG_W-1:0] size_word);
         if (size_word < 2) return 2;
         if (size_word > MAX_SUBSET) return MAX_SUBSET;
         return int'(size_word);
      endfunction

      function void write_register(input logic [CSR_IDX_W-1:0] reg_index,
                                   input logic [VALUE_W-1:0] data);
         if (reg_index == CSR_SUBSET_SIZE) size_reg = data[KCFG_W-1:0];
         else if (reg_index == CSR_MEAN_THRESHOLD) threshold_reg = data;
      endfunction

      // This walks every k-subset in increasing index order. It compares the
      // sum against k * threshold, so no division is needed.
      function logic [CNT_W-1:0] count_qualifying_subsets();
         int               pick [MAX_SUBSET];
         int               k, n, target, sum, pos, i;
         bit               advanced;
         logic [CNT_W-1:0] hits;
         k      = clamp_size(size_reg);
         n      = list_len;
         target = k * int'(threshold_reg);
         hits   = '0;
         if (n < k) return hits;
         for (i = 0; i < k; i++) pick[i] = i;
         do begin
            sum = 0;
            for (i = 0; i < k; i++) sum += int'(values[pick[i]]);
            if (sum >= target && hits != COUNT_MAX) hits++;
            advanced = 1'b0;
            pos      = k;
            while (pos > 0 && !advanced) begin
               pos--;
               if (pick[pos] < n - k + pos) begin
                  pick[pos]++;
                  for (i = pos + 1; i < k; i++) pick[i] = pick[i-1] + 1;
                  advanced = 1'b1;
               end
            end
         end while (advanced);
         return hits;
      endfunction

      function void note_request(input logic signed [VALUE_W-1:0] value, input logic last);
         logic [CNT_W-1:0] expected;
         requests++;
         if (list_len < MAX_ITEMS) begin
            values[list_len] = value;
            list_len++;
         end else begin
            list_overflowed = 1'b1;
         end
         if (last) begin
            expected = count_qualifying_subsets();
            if (list_len < clamp_size(size_reg)) short_lists++;
            if (list_overflowed) long_lists++;
            if (expected > largest_count) largest_count = expected;
            pending_counts.push_back(expected);
            lists_closed++;
            list_len        = 0;
            list_overflowed = 1'b0;
         end
      endfunction

      function void note_failure(input string what);
         mismatches++;
         if (mismatches <= MAX_REPORTS) $display("[%0t] %s", $time, what);
      endfunction

      function void check_result(input logic [CNT_W-1:0] got);
         logic [CNT_W-1:0] want;
         if (pending_counts.size() == 0) begin
            note_failure($sformatf("count %0d arrived with no list closed", got));
            return;
         end
         want = pending_counts.pop_front();
         if (got !== want)
            note_failure($sformatf("subset_count mismatch: expected %0d, got %0d", want, got));
      endfunction

      function int outstanding();
         return pending_counts.size();
      endfunction
   endclass

   logic                        clock;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [VALUE_W-1:0]   req_value;
   logic                        req_is_last;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic        [CNT_W-1:0]     rsp_subset_count;
   logic                        csr_we;
   logic        [CSR_IDX_W-1:0] csr_index;
   logic        [VALUE_W-1:0]   csr_wdata;

   subset_count_board board;
   int                send_idle_pct;
   int                rsp_stall_pct;
   bit                long_hold;
   int                settings_used;

   subset_mean_threshold_count i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_value        (req_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_subset_count (rsp_subset_count),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Both handshakes are observed at the rising edge. Inputs change only at the
   // falling edge, so the values seen here are settled.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) board.note_request(req_value, req_is_last);
         if (rsp_valid && rsp_ready) board.check_result(rsp_subset_count);
      end
   end

   // The receiver stalls at random at the current phase's rate. When the main
   // sequence asks for it, it holds off for a long stretch counted here.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            long_hold = 1'b0;
         end
         rsp_ready <= ($urandom_range(0, 99) >= rsp_stall_pct);
      end
   end

   // The watchdog counts cycles in which neither a request nor a count is
   // accepted. A hung block ends the run here.
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet = 0;
         else quiet++;
      end
      $display("No request or count moved for %0d cycles.", WATCHDOG_LIMIT);
      $display("Test completed with failures");
      $finish;
   end

   // This presents one request and holds it until it is accepted. It may first
   // idle at random. The task is entered and left just after a falling edge.
   task automatic send_request(input logic signed [VALUE_W-1:0] value, input logic last);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid   <= 1'b1;
      req_value   <= value;
      req_is_last <= last;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // The sender stops and waits until every count it expects has arrived. It
   // then waits out the quiet stretch as well.
   task automatic wait_quiet();
      req_valid <= 1'b0;
      while (board.outstanding() != 0) @(posedge clock);
      repeat (QUIET_CYCLES) @(negedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] reg_index,
                            input logic [VALUE_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= reg_index;
      csr_wdata <= data;
      board.write_register(reg_index, data);
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic program_registers(input logic [VALUE_W-1:0] size_word,
                                    input logic signed [VALUE_W-1:0] threshold);
      wait_quiet();
      write_csr(CSR_SUBSET_SIZE, size_word);
      write_csr(CSR_MEAN_THRESHOLD, threshold);
      settings_used++;
   endtask

   function automatic longint binom(input int n, input int k);
      longint c;
      c = 1;
      for (int i = 0; i < k; i++) c = c * (n - i) / (i + 1);
      return c;
   endfunction

   // Values are drawn in several ways. Most lie near the threshold so that
   // counts fall between zero and all. Others are the rails, and others are
   // drawn from the full 16-bit range.
   function automatic logic signed [VALUE_W-1:0] draw_value(input int center, input int spread);
      int v;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 3) v = int'($urandom_range(0, 65535)) - 32768;
      else if (pick == 3) v = $urandom_range(0, 1) ? 32767 : -32768;
      else v = center + int'($urandom_range(0, 2 * spread)) - spread;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return VALUE_W'(v);
   endfunction

   // List length keeps the run time of the count within a budget. With
   // k = 2, lists sometimes run past MAX_ITEMS so that the extra values are
   // dropped. Apart from those, one draw in four picks a length no longer than k.
   function automatic int pick_list_length(input int k);
      int budget;
      int nmax;
      if (k == 2 && $urandom_range(0, 9) == 0)
         return $urandom_range(MAX_ITEMS - 4, MAX_ITEMS + 8);
      if ($urandom_range(0, 3) == 0) return $urandom_range(1, k);
      budget = ($urandom_range(0, 49) == 0) ? BIG_BUDGET : NORMAL_BUDGET;
      nmax   = k;
      while (nmax < MAX_ITEMS && binom(nmax + 1, k) * (k + 3) <= budget) nmax++;
      return $urandom_range(1, nmax);
   endfunction

   function automatic logic signed [VALUE_W-1:0] phase_threshold(input int phase);
      case (phase)
         1:       return 16'sh8000;
         2:       return 16'sh7FFF;
         5:       return 16'sh0000;
         9:       return 16'shFFFF;
         default: return VALUE_W'($urandom_range(0, 65535));
      endcase
   endfunction

   task automatic send_list(input int n, input int center, input int spread);
      for (int i = 0; i < n; i++) send_request(draw_value(center, spread), i == n - 1);
   endtask

   initial begin : main_sequence
      logic [VALUE_W-1:0]        size_word;
      logic signed [VALUE_W-1:0] threshold;
      int                        sent;
      int                        n;
      board         = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_value     = '0;
      req_is_last   = 1'b0;
      csr_we        = 1'b0;
      csr_index     = CSR_SUBSET_SIZE;
      csr_wdata     = '0;
      long_hold     = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      settings_used = 1;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // This part runs under the reset settings, k = 2 and threshold 0. A pair
      // that sums to exactly zero counts as one. A one-value list is shorter
      // than k, so its count is zero.
      send_request(16'sh0100, 1'b0);
      send_request(16'shFF00, 1'b1);
      send_request(16'sh1234, 1'b1);

      // These lists sit at the positive and negative rails. Each subset sum
      // equals k times the threshold exactly, so each count is one.
      program_registers(16'd8, 16'sh7FFF);
      for (int i = 0; i < 8; i++) send_request(16'sh7FFF, i == 7);
      program_registers(16'd3, 16'sh8000);
      for (int i = 0; i < 3; i++) send_request(16'sh8000, i == 2);

      // Here both registers change in the middle of a list. The count must use
      // the values that hold when the last request arrives.
      program_registers(16'd2, 16'sh0000);
      send_request(16'sh0005, 1'b0);
      send_request(16'shFFF9, 1'b0);
      wait_quiet();
      write_csr(CSR_SUBSET_SIZE, 16'd3);
      write_csr(CSR_MEAN_THRESHOLD, 16'shFFFF);
      settings_used++;
      send_request(16'sh0001, 1'b1);

      // In the random phases, each phase uses one subset size, one threshold
      // and one idle mix. The upper bits of the size word are junk that the
      // block must ignore.
      for (int p = 0; p < PHASES; p++) begin
         send_idle_pct = SEND_IDLE[p % 4];
         rsp_stall_pct = RSP_STALL[p % 4];
         size_word     = VALUE_W'($urandom_range(0, 65535));
         size_word[KCFG_W-1:0] = KCFG_W'(SIZE_TABLE[p]);
         threshold     = phase_threshold(p);
         program_registers(size_word, threshold);
         if (p == HOLD_PHASE) long_hold = 1'b1;
         sent = 0;
         while (sent < ITEMS_PER_PHASE) begin
            n = pick_list_length(subset_count_board::clamp_size(size_word[KCFG_W-1:0]));
            send_list(n, int'(threshold), 4 << (4 * $urandom_range(0, 3)));
            sent += n;
         end
      end

      wait_quiet();
      $display("Ran %0d requests in %0d lists across %0d register settings and four idle mixes.",
               board.requests, board.lists_closed, settings_used);
      $display("%0d lists were shorter than k, %0d ran past %0d values, and the largest count was %0d.",
               board.short_lists, board.long_lists, MAX_ITEMS, board.largest_count);
      if (board.mismatches == 0 && board.outstanding() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("%0d mismatches, %0d counts never arrived.", board.mismatches,
                  board.outstanding());
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+design
design/smtc_pkg.sv
design/subset_mean_threshold_count.sv
dv/subset_mean_threshold_count_tb.sv
